// ===== hdl/skgc_pkg.sv =====
package skgc_pkg;

    localparam int FRAC_BITS    = 8;
    localparam int ONE          = 1 << FRAC_BITS;

    localparam int LVL_W        = 16;
    localparam int THR_W        = 16;
    localparam int RAT_W        = 15;
    localparam int KNEE_W       = 13;
    localparam int MKP_W        = 15;
    localparam int GAIN_W       = 16;

    localparam int RATIO_RESET  = 512;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam int REFF_W       = (FRAC_BITS + 1 > RAT_W) ? FRAC_BITS + 1 : RAT_W;
    localparam int DIFF_W       = LVL_W + 2;
    localparam int DK_W         = KNEE_W + 1;
    localparam int XT_W         = LVL_W;
    localparam int SQ_W         = (2 * DK_W > XT_W) ? 2 * DK_W : XT_W;
    localparam int NUM_W        = SQ_W + REFF_W;
    localparam int DEN_W        = KNEE_W + REFF_W + 2;
    localparam int Q_W          = LVL_W;
    localparam int REM_W        = NUM_W + 1;
    localparam int CMP_W        = ((REM_W > DEN_W + Q_W) ? REM_W : DEN_W + Q_W) + 1;
    localparam int SUM_W        = GAIN_W + 2;

    localparam int GAIN_MAX     = (1 << (GAIN_W - 1)) - 1;
    localparam int GAIN_MIN     = -(1 << (GAIN_W - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD,
        CFG_RATIO,
        CFG_KNEE,
        CFG_MAKEUP
    } t_cfg_idx;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [KNEE_W-1:0] knee;
        logic [REFF_W-1:0] ratio;
        logic [REFF_W-1:0] ratio_m1;
    } t_cfg;

    typedef struct packed {
        logic             zero;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

endpackage

// ===== hdl/skgc_front.sv =====
module skgc_front
    import skgc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [LVL_W-1:0] i_level_db,
    output logic             o_valid,
    input  logic             i_ready,
    output t_div_req         o_req
);

    logic                     en_a;
    logic                     en_b;
    logic                     en_c;

    logic signed [DIFF_W-1:0] xt_full;
    logic signed [DIFF_W-1:0] d_full;
    logic signed [DIFF_W-1:0] knee_s;
    logic [KNEE_W+REFF_W-1:0] kr;
    logic [2*DK_W-1:0]        dd;

    logic                     r_a_v;
    logic                     r_a_below;
    logic                     r_a_knee;
    logic [DK_W-1:0]          r_a_d;
    logic [XT_W-1:0]          r_a_xt;
    logic [DEN_W-1:0]         r_a_kr4;

    logic                     r_b_v;
    logic                     r_b_zero;
    logic [SQ_W-1:0]          r_b_sq;
    logic [DEN_W-1:0]         r_b_den;

    logic                     r_c_v;
    t_div_req                 r_c_req;

    assign en_c    = !r_c_v || i_ready;
    assign en_b    = !r_b_v || en_c;
    assign en_a    = !r_a_v || en_b;
    assign o_ready = en_a;
    assign o_valid = r_c_v;
    assign o_req   = r_c_req;

    always_comb begin
        knee_s  = $signed({{(DIFF_W-KNEE_W){1'b0}}, i_cfg.knee});
        xt_full = $signed({{(DIFF_W-LVL_W){i_level_db[LVL_W-1]}}, i_level_db})
                - $signed({{(DIFF_W-THR_W){i_cfg.threshold[THR_W-1]}}, i_cfg.threshold});
        d_full  = xt_full + knee_s;
        kr      = i_cfg.knee * i_cfg.ratio;
        dd      = r_a_d * r_a_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (en_a) r_a_v <= i_valid;
            if (en_b) r_b_v <= r_a_v;
            if (en_c) r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_below <= d_full[DIFF_W-1];
            r_a_knee  <= xt_full < knee_s;
            r_a_d     <= d_full[DK_W-1:0];
            r_a_xt    <= xt_full[XT_W-1:0];
            r_a_kr4   <= {kr, 2'b00};
        end
        if (en_b) begin
            r_b_zero <= r_a_below;
            r_b_sq   <= r_a_knee ? SQ_W'(dd) : SQ_W'(r_a_xt);
            r_b_den  <= r_a_knee ? r_a_kr4 : DEN_W'(i_cfg.ratio);
        end
        if (en_c) begin
            r_c_req.zero <= r_b_zero;
            r_c_req.num  <= r_b_sq * i_cfg.ratio_m1;
            r_c_req.den  <= r_b_den;
        end
    end

endmodule

// ===== hdl/skgc_div.sv =====
module skgc_div
    import skgc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  t_div_req       i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_zero,
    output logic [Q_W-1:0] o_quot
);

    logic [Q_W:0]     en;
    logic [Q_W:0]     r_v;
    logic [REM_W-1:0] r_rem  [Q_W+1];
    logic [Q_W-1:0]   r_q    [Q_W+1];
    logic [DEN_W-1:0] r_den  [Q_W+1];
    logic             r_zero [Q_W+1];

    always_comb begin
        en[Q_W] = !r_v[Q_W] || i_ready;
        for (int j = Q_W - 1; j >= 0; j--) begin
            en[j] = !r_v[j] || en[j+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[Q_W];
    assign o_zero  = r_zero[Q_W];
    assign o_quot  = r_q[Q_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en[0]) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_rem[0]  <= REM_W'(i_req.num) + REM_W'(i_req.den >> 1);
            r_q[0]    <= '0;
            r_den[0]  <= i_req.den;
            r_zero[0] <= i_req.zero;
        end
    end

    for (genvar j = 1; j <= Q_W; j++) begin : g_bit
        localparam int BIT = Q_W - j;

        logic [CMP_W-1:0] dsh;
        logic [CMP_W-1:0] rem_ext;
        logic             ge;

        assign dsh     = CMP_W'(r_den[j-1]) << BIT;
        assign rem_ext = CMP_W'(r_rem[j-1]);
        assign ge      = rem_ext >= dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (en[j]) begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[j]) begin
                r_rem[j]  <= ge ? REM_W'(rem_ext - dsh) : r_rem[j-1];
                r_q[j]    <= ge ? (r_q[j-1] | (Q_W'(1) << BIT)) : r_q[j-1];
                r_den[j]  <= r_den[j-1];
                r_zero[j] <= r_zero[j-1];
            end
        end
    end

endmodule

// ===== hdl/soft_knee_gain_computer_unit.sv =====
// Soft-knee compressor gain computer.
// Input channel: i_valid / o_ready carry one detected level (i_level_db,
// signed dB with FRAC_BITS fraction bits). Output channel: o_valid / i_ready
// carry one gain (o_gain_db, same format, makeup added, saturated to 16 bits).
// Configuration: i_cfg_valid / o_cfg_ready write i_cfg_data to the register
// named by i_cfg_index (threshold, ratio, knee half-width, makeup). The port
// is always ready; write only while no request is in flight.
// Pipeline from input acceptance to output valid: offset/product, square and
// numerator registers, a rounding-bias register, sixteen restoring division
// stages (one quotient bit per stage), and a saturation/output register.
// Throughput: one request per cycle while the receiver does not stall; the divider is fully pipelined.
// Reset clears all pipeline valid bits and loads the register defaults
// (threshold 0, ratio 2.0, hard knee, no makeup).
// When the receiver stalls, each stage holds; empty stages keep filling, so
// the input keeps accepting until the pipeline is full, then o_ready drops.
module soft_knee_gain_computer_unit
    import skgc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [LVL_W-1:0]      i_level_db,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [GAIN_W-1:0]     o_gain_db,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [THR_W-1:0]        r_threshold;
    logic [RAT_W-1:0]        r_ratio;
    logic [KNEE_W-1:0]       r_knee;
    logic [MKP_W-1:0]        r_makeup;

    t_cfg                    cfg;
    t_div_req                req;
    logic                    req_valid;
    logic                    req_ready;
    logic                    div_valid;
    logic                    div_ready;
    logic                    div_zero;
    logic [Q_W-1:0]          div_quot;

    logic signed [SUM_W-1:0] sum;
    logic [GAIN_W-1:0]       sat;
    logic                    en_out;
    logic                    r_out_v;
    logic [GAIN_W-1:0]       r_gain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_ratio     <= RAT_W'(RATIO_RESET);
            r_knee      <= '0;
            r_makeup    <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                CFG_RATIO:     r_ratio     <= i_cfg_data[RAT_W-1:0];
                CFG_KNEE:      r_knee      <= i_cfg_data[KNEE_W-1:0];
                CFG_MAKEUP:    r_makeup    <= i_cfg_data[MKP_W-1:0];
            endcase
        end
    end

    always_comb begin
        cfg.threshold = r_threshold;
        cfg.knee      = r_knee;
        cfg.ratio     = (REFF_W'(r_ratio) < REFF_W'(ONE)) ? REFF_W'(ONE) : REFF_W'(r_ratio);
        cfg.ratio_m1  = cfg.ratio - REFF_W'(ONE);
    end

    skgc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_level_db (i_level_db),
        .o_valid    (req_valid),
        .i_ready    (req_ready),
        .o_req      (req)
    );

    skgc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (req_valid),
        .o_ready (req_ready),
        .i_req   (req),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_zero  (div_zero),
        .o_quot  (div_quot)
    );

    always_comb begin
        sum = $signed({{(SUM_W-MKP_W){r_makeup[MKP_W-1]}}, r_makeup})
            - (div_zero ? SUM_W'(0) : $signed({{(SUM_W-Q_W){1'b0}}, div_quot}));
        if (sum > SUM_W'(GAIN_MAX)) begin
            sat = GAIN_W'(GAIN_MAX);
        end else if (sum < SUM_W'(GAIN_MIN)) begin
            sat = GAIN_W'(GAIN_MIN);
        end else begin
            sat = sum[GAIN_W-1:0];
        end
    end

    assign en_out    = !r_out_v || i_ready;
    assign div_ready = en_out;
    assign o_valid   = r_out_v;
    assign o_gain_db = r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en_out) begin
            r_out_v <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_gain <= sat;
        end
    end

endmodule

// ===== dv/soft_knee_gain_computer_unit_tb.sv =====
`timescale 1ns / 1ps

module soft_knee_gain_computer_unit_tb
    import skgc_pkg::*;
;

    localparam int RAND_PHASES     = 10;
    localparam int PHASE_ITEMS     = 108;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int TAIL_CYCLES     = 30;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef struct {
        logic signed [LVL_W-1:0]  level;
        logic signed [GAIN_W-1:0] gain;
    } t_gain_entry;

    class t_gain_checker;
        logic signed [THR_W-1:0] threshold;
        logic [RAT_W-1:0]        ratio;
        logic [KNEE_W-1:0]       knee;
        logic signed [MKP_W-1:0] makeup;
        t_gain_entry             expected_gains[$];
        int                      errors;
        int                      n_levels;
        int                      n_gains;

        function new();
            threshold = '0;
            ratio     = RAT_W'(RATIO_RESET);
            knee      = '0;
            makeup    = '0;
            errors    = 0;
            n_levels  = 0;
            n_gains   = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_THRESHOLD: threshold = data[THR_W-1:0];
                CFG_RATIO:     ratio     = data[RAT_W-1:0];
                CFG_KNEE:      knee      = data[KNEE_W-1:0];
                CFG_MAKEUP:    makeup    = data[MKP_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [GAIN_W-1:0] predict_gain(logic signed [LVL_W-1:0] lvl);
            longint x, t, k, r, d, num, den, m, total;
            x = lvl;
            t = threshold;
            k = knee;
            r = ratio;
            if (r < ONE) r = ONE;
            if (x < t - k) begin
                m = 0;
            end else if (x < t + k) begin
                d   = x - t + k;
                num = d * d * (r - ONE);
                den = 4 * k * r;
                m   = (num + den / 2) / den;
            end else begin
                num = (x - t) * (r - ONE);
                m   = (num + r / 2) / r;
            end
            total = longint'(makeup) - m;
            if (total > GAIN_MAX) total = GAIN_MAX;
            if (total < GAIN_MIN) total = GAIN_MIN;
            return GAIN_W'(total);
        endfunction

        function void note_level(logic [LVL_W-1:0] lvl);
            t_gain_entry e;
            e.level = lvl;
            e.gain  = predict_gain(lvl);
            expected_gains.push_back(e);
            n_levels++;
        endfunction

        function void check_gain(logic [GAIN_W-1:0] act);
            t_gain_entry e;
            n_gains++;
            if (expected_gains.size() == 0) begin
                $display("%0t unexpected gain %0d, nothing expected", $time, $signed(act));
                errors++;
            end else begin
                e = expected_gains.pop_front();
                if (e.gain !== act) begin
                    $display("%0t gain mismatch for level %0d: expected %0d, actual %0d",
                             $time, e.level, e.gain, $signed(act));
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_gains.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [LVL_W-1:0]      i_level_db;
    logic                  o_valid;
    logic                  i_ready;
    logic [GAIN_W-1:0]     o_gain_db;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    t_gain_checker gains;
    bit          no_idle   = 1'b0;
    bit          long_hold = 1'b0;
    int          n_writes  = 0;
    int          n_settings = 0;
    int          idle_cycles;

    soft_knee_gain_computer_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_level_db  (i_level_db),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_gain_db   (o_gain_db),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) gains.note_level(i_level_db);
            if (o_valid && i_ready) gains.check_gain(o_gain_db);
            if (i_cfg_valid && o_cfg_ready) gains.set_reg(t_cfg_idx'(i_cfg_index), i_cfg_data);
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t watchdog: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int send_gap();
        if (no_idle || $urandom_range(0, 1) == 0) return 0;
        return idle_len();
    endfunction

    function automatic int rand_level();
        int t, k, v;
        t = gains.threshold;
        k = gains.knee;
        case ($urandom_range(0, 9))
            0, 1, 2: v = int'($urandom_range(0, 65535)) - 32768;
            3: begin
                case ($urandom_range(0, 3))
                    0:       v = t - k - 1;
                    1:       v = t - k;
                    2:       v = t + k - 1;
                    default: v = t + k;
                endcase
            end
            default: v = t - k - 256 + int'($urandom_range(0, 2 * k + 512));
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    // receiver side: random back-pressure, with one long hold-off on request
    initial begin
        i_ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (no_idle || $urandom_range(0, 3) != 0) begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b0;
                repeat (idle_len()) @(posedge i_clk);
            end
        end
    end

    task automatic send_level(input int lvl);
        int gap;
        gap = send_gap();
        i_valid    <= 1'b1;
        i_level_db <= LVL_W'(lvl);
        do @(posedge i_clk); while (!o_ready);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_gains();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (gains.pending() != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_writes++;
        @(posedge i_clk);
    endtask

    task automatic configure(input int thr, input int rat, input int knee, input int mkp);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_RATIO, rat);
        write_reg(CFG_KNEE, knee);
        write_reg(CFG_MAKEUP, mkp);
        n_settings++;
    endtask

    task automatic random_settings();
        int thr, rat, knee, mkp;
        case ($urandom_range(0, 5))
            0:       thr = -16896;
            1:       thr = 1536;
            2:       thr = $urandom_range(0, 65535);
            default: thr = int'($urandom_range(0, 18432)) - 16896;
        endcase
        case ($urandom_range(0, 6))
            0:       rat = 256;
            1:       rat = 16384;
            2:       rat = $urandom_range(0, 255);
            3:       rat = $urandom_range(0, 65535);
            default: rat = $urandom_range(256, 16384);
        endcase
        case ($urandom_range(0, 5))
            0:       knee = 0;
            1:       knee = 4608;
            2:       knee = $urandom_range(0, 65535);
            default: knee = $urandom_range(0, 4608);
        endcase
        case ($urandom_range(0, 5))
            0:       mkp = -9216;
            1:       mkp = 9216;
            2:       mkp = $urandom_range(0, 65535);
            default: mkp = int'($urandom_range(0, 18432)) - 9216;
        endcase
        configure(thr, rat, knee, mkp);
    endtask

    initial begin
        gains = new();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_level_db  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_THRESHOLD;
        i_cfg_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: threshold 0, ratio 2, hard knee
        send_level(-32768);
        send_level(32767);
        send_level(0);
        send_level(-1);
        send_level(1);
        send_level(256);

        // soft knee, edges of the quadratic region
        wait_for_gains();
        configure(-2560, 1024, 1536, 1280);
        send_level(-4097);
        send_level(-4096);
        send_level(-4095);
        send_level(-2560);
        send_level(-1025);
        send_level(-1024);
        send_level(-32768);
        send_level(32767);

        // ratio below unity and zero ratio
        wait_for_gains();
        configure(0, 0, 512, 0);
        send_level(0);
        send_level(300);
        send_level(32767);
        wait_for_gains();
        write_reg(CFG_RATIO, 255);
        send_level(1000);

        // deepest gain saturates with the lowest makeup
        wait_for_gains();
        configure(16'h8000, 16'hFFFF, 0, 16'h4000);
        send_level(32767);
        send_level(-32768);

        // widest knee
        wait_for_gains();
        configure(0, 16384, 16'h1FFF, 0);
        send_level(-8191);
        send_level(0);
        send_level(8190);

        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_for_gains();
            if (p == 0)
                configure(-16896, 256, 0, -9216);
            else if (p == 1)
                configure(1536, 16384, 4608, 9216);
            else
                random_settings();
            no_idle = (p == 2 || p == 3);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 3 && i == 20) long_hold = 1'b1;
                if (p == 4 && i == PHASE_ITEMS / 2) wait_for_gains();
                send_level(rand_level());
            end
            no_idle = 1'b0;
        end

        wait_for_gains();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("checked %0d gains for %0d levels over %0d settings (%0d register writes)",
                 gains.n_gains, gains.n_levels, n_settings, n_writes);
        $display("hard and soft knee, sub-unity ratio, saturation and a full-pipeline stall");
        if (gains.errors == 0 && gains.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/skgc_pkg.sv
hdl/skgc_front.sv
hdl/skgc_div.sv
hdl/soft_knee_gain_computer_unit.sv
dv/soft_knee_gain_computer_unit_tb.sv
